// ===== hdl/gmi_pkg.sv =====
`default_nettype none
package gmi_pkg;

  // x and r values, signed Q2.16
  typedef logic signed [17:0] xval_t;

  localparam xval_t X_MAX = 18'sh1ffff;
  localparam xval_t X_MIN = 18'sh20000;

  // register select, taken from paddr[2]
  typedef enum logic {
    REG_ITER = 1'b0,
    REG_GAIN = 1'b1
  } reg_sel_t;

  localparam logic [6:0]  ITER_RESET = 7'd10;
  localparam logic [15:0] GAIN_RESET = 16'd3072;

  // loop depth: one application takes this many register stages
  localparam int unsigned LOOP_STAGES = 5;

endpackage
`default_nettype wire

// ===== hdl/gauss_map_iterator_unit.sv =====
// items: up to five items share the five-stage map loop and its credits; each item makes
//   n = min(iterations, MAX_ITER) passes, or one pass that leaves x unchanged when
//   iterations is zero; one pass runs through the loop depth of squarer, gain multiply,
//   exp rom read, interpolation multiply and add/saturate
// reset: synchronous, clears loop valid bits, result queue and registers to iterations 10,
//   gain_t 3072
`default_nettype none
module gauss_map_iterator_unit
  import gmi_pkg::*;
#(
  parameter int unsigned MAX_ITER        = 64,
  parameter int unsigned EXP_TABLE_DEPTH = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [17:0] r_value,
  input  wire logic signed [17:0] x_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [17:0]      x_final
);

  localparam int unsigned AW = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned CW = $clog2(MAX_ITER + 1);
  localparam int unsigned QD = 8;
  localparam int unsigned QW = $clog2(QD);

  typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // entry k = round(65536 * e^(-k/128)) in Q1.16
  function automatic rom_t build_exp_rom();
    logic [63:0]  term;
    logic [63:0]  step;
    logic [63:0]  v;
    logic [127:0] p;
    rom_t         t;
    term = 64'h4000_0000_0000_0000;
    step = term;
    v    = term;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term, 64'(128 * n));
      if (n % 2 == 1) step = step - term;
      else            step = step + term;
    end
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      t[k] = 17'((v + (64'd1 << 45)) >> 46);
      p    = {64'd0, v} * {64'd0, step};
      v    = p[125:62];
    end
    return t;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

  // configuration registers
  logic [6:0]  iterations;
  logic [15:0] gain_t;
  logic        cfg_wr;
  reg_sel_t    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      iterations <= ITER_RESET;
      gain_t     <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ITER: iterations <= pwdata[6:0];
        REG_GAIN: gain_t     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ITER: prdata = {25'd0, iterations};
      REG_GAIN: prdata = {16'd0, gain_t};
      default:  prdata = '0;
    endcase
  end

  // clamped application count
  logic [CW-1:0] iter_clamp;
  assign iter_clamp = (32'(iterations) > MAX_ITER) ? CW'(MAX_ITER) : CW'(iterations);

  // loop stage registers
  logic          s1_v, s2_v, s3_v, s4_v, s5_v;
  xval_t         s1_r, s2_r, s3_r, s4_r, s5_r;
  xval_t         s1_x, s2_x, s3_x, s4_x, s5_x;
  logic [CW-1:0] s1_cnt, s2_cnt, s3_cnt, s4_cnt, s5_cnt;
  logic [35:0]   s1_sq;
  logic [51:0]   s2_prod;
  logic [16:0]   s3_a, s3_b;
  logic [15:0]   s3_frac;
  logic          s3_over, s3_last;
  logic [32:0]   s4_diff;
  logic [16:0]   s4_a;
  logic          s4_over;

  // credit and queue state
  logic [2:0]    inflight;
  logic          head_exit, take, pop;

  assign head_exit = s5_v && (s5_cnt == '0);
  assign in_ready  = (inflight < 3'(LOOP_STAGES)) && (!s5_v || head_exit);
  assign take      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // loop entry: new item or recirculated one
  logic          e_v;
  xval_t         e_r, e_x;
  logic [CW-1:0] e_cnt;
  logic [17:0]   e_mag;

  always_comb begin
    if (take) begin
      e_v   = 1'b1;
      e_r   = r_value;
      e_x   = x_start;
      e_cnt = iter_clamp;
    end else begin
      e_v   = s5_v && !head_exit;
      e_r   = s5_r;
      e_x   = s5_x;
      e_cnt = s5_cnt;
    end
    e_mag = e_x[17] ? 18'(-e_x) : 18'(e_x);
  end

  // stage 1: square
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= e_v;
    s1_r   <= e_r;
    s1_x   <= e_x;
    s1_cnt <= e_cnt;
    s1_sq  <= {18'd0, e_mag} * {18'd0, e_mag};
  end

  // stage 2: times gain
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
    s2_r    <= s1_r;
    s2_x    <= s1_x;
    s2_cnt  <= s1_cnt;
    s2_prod <= s1_sq * {36'd0, gain_t};
  end

  // stage 3: rom read of two neighbors
  logic [16:0]   idx;
  logic [AW-1:0] addr_a, addr_b;

  assign idx    = s2_prod[51:35];
  assign addr_a = idx[AW-1:0];
  assign addr_b = addr_a + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else     s3_v <= s2_v;
    s3_r    <= s2_r;
    s3_x    <= s2_x;
    s3_cnt  <= s2_cnt;
    s3_frac <= s2_prod[34:19];
    s3_over <= (idx >= 17'(EXP_TABLE_DEPTH));
    s3_last <= (idx == 17'(EXP_TABLE_DEPTH - 1));
    s3_a    <= EXP_ROM[addr_a];
    s3_b    <= EXP_ROM[addr_b];
  end

  // stage 4: interpolation product
  logic [16:0] b_eff;
  assign b_eff = s3_last ? 17'd0 : s3_b;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else     s4_v <= s3_v;
    s4_r    <= s3_r;
    s4_x    <= s3_x;
    s4_cnt  <= s3_cnt;
    s4_a    <= s3_a;
    s4_over <= s3_over;
    s4_diff <= {16'd0, s3_a - b_eff} * {17'd0, s3_frac};
  end

  // stage 5: round, add r, saturate and count down; x passes unchanged when the count is zero
  logic [32:0]        rnd;
  logic [16:0]        e_val;
  logic signed [19:0] sum;
  xval_t              x_sat;
  logic               live;

  always_comb begin
    rnd   = s4_diff + 33'd32768;
    e_val = s4_over ? 17'd0 : (s4_a - rnd[32:16]);
    sum   = $signed({3'd0, e_val}) + 20'(s4_r);
    if (sum > 20'(X_MAX))      x_sat = X_MAX;
    else if (sum < 20'(X_MIN)) x_sat = X_MIN;
    else                       x_sat = sum[17:0];
    live  = (s4_cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else     s5_v <= s4_v;
    s5_r   <= s4_r;
    s5_x   <= live ? x_sat : s4_x;
    s5_cnt <= live ? s4_cnt - CW'(1) : s4_cnt;
  end

  // result queue, space guaranteed by the credit count
  xval_t         q_mem [QD];
  logic [QW-1:0] q_wr, q_rd;
  logic [QW:0]   q_cnt;

  always_ff @(posedge clk) begin
    if (head_exit) q_mem[q_wr] <= s5_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr     <= '0;
      q_rd     <= '0;
      q_cnt    <= '0;
      inflight <= '0;
    end else begin
      if (head_exit) q_wr <= q_wr + QW'(1);
      if (pop)       q_rd <= q_rd + QW'(1);
      q_cnt    <= q_cnt + (QW+1)'(head_exit) - (QW+1)'(pop);
      inflight <= inflight + 3'(take) - 3'(pop);
    end
  end

  assign out_valid = (q_cnt != '0);
  assign x_final   = q_mem[q_rd];

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= 3'(LOOP_STAGES))
    else $error("more items in flight than loop slots");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    head_exit |-> (q_cnt < (QW+1)'(QD)))
    else $error("result queue overflow");

  a_out_has_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inflight != '0))
    else $error("result without an item in flight");

  a_no_admit_busy_slot: assert property (@(posedge clk) disable iff (rst)
    take |-> (!s5_v || head_exit))
    else $error("item admitted into an occupied loop slot");

endmodule
`default_nettype wire
